### hw/rtl/puf_pkg.sv
// Shared types and constants for the persistent union-find block.
// No dependencies; used by every module under hw/rtl.
package puf_pkg;

    localparam int NODES      = 1024;
    localparam int NODE_W     = 10;
    localparam int HEAD_W     = 11;
    localparam int SIZE_W     = 11;
    localparam int TIME_W     = 60;
    localparam int USED_W     = 12;
    localparam int HIST_DEPTH = 2 * NODES;

    localparam logic [1:0] OP_UNITE = 2'd0;
    localparam logic [1:0] OP_SAME  = 2'd1;
    localparam logic [1:0] OP_SIZE  = 2'd2;

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic              linked;
        logic [TIME_W-1:0] lt;
        logic [NODE_W-1:0] parent;
    } t_node_ent;

    typedef struct packed {
        logic [HEAD_W-1:0] prev;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] tstamp;
    } t_hist_ent;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        t_node_ent         data;
    } t_node_wr;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        t_hist_ent         data;
    } t_hist_wr;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_WALK, ST_CHK, ST_SZX, ST_SZY, ST_SZY_CHK,
        ST_LINK, ST_HEAD, ST_HIST, ST_HCHK, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_A, PH_B, PH_FIN
    } t_phase;

endpackage

### hw/rtl/puf_node_mem.sv
// Node store: parent, link time, link flag and size-history head per node.
// One write port, one registered read port. Depends on puf_pkg.
module puf_node_mem (
    input  logic                       i_clk,
    input  puf_pkg::t_node_wr          i_wr,
    input  logic [puf_pkg::NODE_W-1:0] i_rd_addr,
    output puf_pkg::t_node_ent         o_rd_data
);

    puf_pkg::t_node_ent mem [puf_pkg::NODES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

### hw/rtl/puf_hist_mem.sv
// Size-history store for entries added by unites (upper half of the history).
// One write port, one registered read port. Depends on puf_pkg.
module puf_hist_mem (
    input  logic                       i_clk,
    input  puf_pkg::t_hist_wr          i_wr,
    input  logic [puf_pkg::NODE_W-1:0] i_rd_addr,
    output puf_pkg::t_hist_ent         o_rd_data
);

    puf_pkg::t_hist_ent mem [puf_pkg::NODES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

### hw/rtl/puf_seq.sv
// Operation sequencer: root walks, size-history walks, unite writes, result register.
// Depends on puf_pkg; drives puf_node_mem and puf_hist_mem.
module puf_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_opcode,
    input  logic [puf_pkg::NODE_W-1:0] i_node_a,
    input  logic [puf_pkg::NODE_W-1:0] i_node_b,
    input  logic [puf_pkg::TIME_W-1:0] i_time,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_flag,
    output logic [puf_pkg::SIZE_W-1:0] o_size,
    output logic                       o_status,
    output puf_pkg::t_node_wr          o_node_wr,
    output logic [puf_pkg::NODE_W-1:0] o_node_rd_addr,
    input  puf_pkg::t_node_ent         i_node_q,
    output puf_pkg::t_hist_wr          o_hist_wr,
    output logic [puf_pkg::NODE_W-1:0] o_hist_rd_addr,
    input  puf_pkg::t_hist_ent         i_hist_q
);

    puf_pkg::t_state r_state, n_state;
    puf_pkg::t_phase r_phase, n_phase;

    logic [1:0]                 r_op, n_op;
    logic [puf_pkg::NODE_W-1:0] r_a, n_a, r_b, n_b, r_n, n_n, r_x, n_x, r_y, n_y;
    logic [puf_pkg::TIME_W-1:0] r_t, n_t, r_last, n_last;
    puf_pkg::t_node_ent         r_ex, n_ex, r_ey, n_ey;
    logic [puf_pkg::SIZE_W-1:0] r_sx, n_sx, r_sy, n_sy, r_res_size, n_res_size;
    logic [puf_pkg::HEAD_W-1:0] r_e, n_e;
    logic [puf_pkg::USED_W-1:0] r_used, n_used;
    logic                       r_flag, n_flag, r_status, n_status;
    logic                       r_o_valid, n_o_valid, r_o_flag, n_o_flag, r_o_status, n_o_status;
    logic [puf_pkg::SIZE_W-1:0] r_o_size, n_o_size;
    logic                       swap;

    assign swap = r_sx > r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= puf_pkg::ST_CLEAR;
            r_phase   <= puf_pkg::PH_A;
            r_n       <= '0;
            r_used    <= puf_pkg::USED_W'(puf_pkg::NODES);
            r_last    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_n       <= n_n;
            r_used    <= n_used;
            r_last    <= n_last;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_a        <= n_a;
        r_b        <= n_b;
        r_x        <= n_x;
        r_y        <= n_y;
        r_t        <= n_t;
        r_ex       <= n_ex;
        r_ey       <= n_ey;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_res_size <= n_res_size;
        r_e        <= n_e;
        r_flag     <= n_flag;
        r_status   <= n_status;
        r_o_flag   <= n_o_flag;
        r_o_size   <= n_o_size;
        r_o_status <= n_o_status;
    end

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_op           = r_op;
        n_a            = r_a;
        n_b            = r_b;
        n_n            = r_n;
        n_x            = r_x;
        n_y            = r_y;
        n_t            = r_t;
        n_last         = r_last;
        n_ex           = r_ex;
        n_ey           = r_ey;
        n_sx           = r_sx;
        n_sy           = r_sy;
        n_res_size     = r_res_size;
        n_e            = r_e;
        n_used         = r_used;
        n_flag         = r_flag;
        n_status       = r_status;
        n_o_valid      = r_o_valid & ~i_out_ready;
        n_o_flag       = r_o_flag;
        n_o_size       = r_o_size;
        n_o_status     = r_o_status;
        o_in_ready     = 1'b0;
        o_node_wr      = '0;
        o_node_rd_addr = r_n;
        o_hist_wr      = '0;
        o_hist_rd_addr = r_e[puf_pkg::NODE_W-1:0];

        case (r_state)
            puf_pkg::ST_CLEAR: begin
                o_node_wr.en               = 1'b1;
                o_node_wr.addr             = r_n;
                o_node_wr.data.parent      = r_n;
                o_node_wr.data.lt          = '0;
                o_node_wr.data.linked      = 1'b0;
                o_node_wr.data.head        = {1'b0, r_n};
                n_n = r_n + 1'b1;
                if (r_n == puf_pkg::NODE_W'(puf_pkg::NODES - 1)) begin
                    n_state = puf_pkg::ST_IDLE;
                end
            end
            puf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_a      = i_node_a;
                    n_b      = i_node_b;
                    n_t      = i_time;
                    n_n      = i_node_a;
                    n_flag   = 1'b0;
                    n_status = 1'b0;
                    n_state  = puf_pkg::ST_WALK;
                    if (i_opcode == puf_pkg::OP_UNITE && i_time < r_last) begin
                        n_status = 1'b1;
                        n_phase  = puf_pkg::PH_FIN;
                    end else if (i_opcode == puf_pkg::OP_UNITE ||
                                 i_opcode == puf_pkg::OP_SAME) begin
                        n_phase = puf_pkg::PH_A;
                    end else begin
                        n_phase = puf_pkg::PH_FIN;
                    end
                end
            end
            puf_pkg::ST_WALK: begin
                n_state = puf_pkg::ST_CHK;
            end
            puf_pkg::ST_CHK: begin
                if (i_node_q.linked && i_node_q.lt <= r_t) begin
                    n_n            = i_node_q.parent;
                    o_node_rd_addr = i_node_q.parent;
                end else begin
                    case (r_phase)
                        puf_pkg::PH_A: begin
                            n_x     = r_n;
                            n_ex    = i_node_q;
                            n_n     = r_b;
                            n_phase = puf_pkg::PH_B;
                            n_state = puf_pkg::ST_WALK;
                        end
                        puf_pkg::PH_B: begin
                            n_y     = r_n;
                            n_ey    = i_node_q;
                            n_n     = r_a;
                            n_phase = puf_pkg::PH_FIN;
                            n_state = puf_pkg::ST_WALK;
                            if (r_op == puf_pkg::OP_SAME) begin
                                n_flag = (r_x == r_n);
                            end else begin
                                n_last = r_t;
                                if (r_x != r_n && !r_used[puf_pkg::USED_W-1]) begin
                                    n_state = puf_pkg::ST_SZX;
                                end
                            end
                        end
                        default: begin
                            n_e     = i_node_q.head;
                            n_state = puf_pkg::ST_HIST;
                        end
                    endcase
                end
            end
            puf_pkg::ST_SZX: begin
                o_hist_rd_addr = r_ex.head[puf_pkg::NODE_W-1:0];
                n_state = puf_pkg::ST_SZY;
            end
            puf_pkg::ST_SZY: begin
                n_sx = r_ex.head[puf_pkg::NODE_W] ? i_hist_q.size : puf_pkg::SIZE_W'(1);
                o_hist_rd_addr = r_ey.head[puf_pkg::NODE_W-1:0];
                n_state = puf_pkg::ST_SZY_CHK;
            end
            puf_pkg::ST_SZY_CHK: begin
                n_sy = r_ey.head[puf_pkg::NODE_W] ? i_hist_q.size : puf_pkg::SIZE_W'(1);
                n_state = puf_pkg::ST_LINK;
            end
            puf_pkg::ST_LINK: begin
                o_node_wr.en          = 1'b1;
                o_node_wr.addr        = swap ? r_y : r_x;
                o_node_wr.data.parent = swap ? r_x : r_y;
                o_node_wr.data.lt     = r_t;
                o_node_wr.data.linked = 1'b1;
                o_node_wr.data.head   = swap ? r_ey.head : r_ex.head;
                o_hist_wr.en          = 1'b1;
                o_hist_wr.addr        = r_used[puf_pkg::NODE_W-1:0];
                o_hist_wr.data.tstamp = r_t;
                o_hist_wr.data.size   = r_sx + r_sy;
                o_hist_wr.data.prev   = swap ? r_ex.head : r_ey.head;
                n_state = puf_pkg::ST_HEAD;
            end
            puf_pkg::ST_HEAD: begin
                o_node_wr.en   = 1'b1;
                o_node_wr.addr = swap ? r_x : r_y;
                o_node_wr.data = swap ? r_ex : r_ey;
                o_node_wr.data.head = r_used[puf_pkg::HEAD_W-1:0];
                n_used  = r_used + 1'b1;
                n_flag  = 1'b1;
                n_state = puf_pkg::ST_WALK;
            end
            puf_pkg::ST_HIST: begin
                if (!r_e[puf_pkg::NODE_W]) begin
                    n_res_size = puf_pkg::SIZE_W'(1);
                    n_state    = puf_pkg::ST_OUT;
                end else begin
                    n_state = puf_pkg::ST_HCHK;
                end
            end
            puf_pkg::ST_HCHK: begin
                if (i_hist_q.tstamp <= r_t) begin
                    n_res_size = i_hist_q.size;
                    n_state    = puf_pkg::ST_OUT;
                end else if (!i_hist_q.prev[puf_pkg::NODE_W]) begin
                    n_res_size = puf_pkg::SIZE_W'(1);
                    n_state    = puf_pkg::ST_OUT;
                end else begin
                    n_e            = i_hist_q.prev;
                    o_hist_rd_addr = i_hist_q.prev[puf_pkg::NODE_W-1:0];
                end
            end
            puf_pkg::ST_OUT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_flag   = r_flag;
                    n_o_size   = r_res_size;
                    n_o_status = r_status;
                    n_state    = puf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = puf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_o_valid;
    assign o_flag      = r_o_flag;
    assign o_size      = r_o_size;
    assign o_status    = r_o_status;

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used >= puf_pkg::USED_W'(puf_pkg::NODES) &&
        r_used <= puf_pkg::USED_W'(puf_pkg::HIST_DEPTH))
        else $error("history fill count out of range");

    a_link_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == puf_pkg::ST_LINK |-> r_x != r_y)
        else $error("link of a root to itself");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == puf_pkg::ST_HEAD |=> r_used == $past(r_used) + 1'b1)
        else $error("history fill count did not advance");

    a_refused_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_status |-> !r_o_flag)
        else $error("refused unite reports a join");

endmodule

### hw/rtl/persistent_union_find.sv
// Top level of the partially persistent union-find: stream ports, field packing.
// Depends on puf_pkg, puf_node_mem, puf_hist_mem and puf_seq.
//
//  port group   dir  carries
//  i_s_axis_*   in   one operation per transfer (opcode in tuser)
//  o_m_axis_*   out  one result per operation
//
// A root walk follows each parent link in turn, one node read per cycle.
// A taken unite or a same-set query walks three times, a size query or a refused unite
// once; a join adds the states SZX, SZY, SZY_CHK, LINK and HEAD, and the size lookup
// walks the size history in ST_HCHK, passing each entry newer than the query time.
// After reset a pass over all 1024 nodes initializes the node memory; tready stays low.
// One item is in work at a time; the next is taken while a result waits.
module persistent_union_find (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,   // node_a[9:0], node_b[19:10], query_time[79:20]
    input  logic [1:0]  i_s_axis_tuser,   // opcode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // answer_flag[0], component_size[11:1], status[12]
);

    puf_pkg::t_node_wr                node_wr;
    puf_pkg::t_node_ent               node_q;
    puf_pkg::t_hist_wr                hist_wr;
    puf_pkg::t_hist_ent               hist_q;
    logic [puf_pkg::NODE_W-1:0]       node_rd_addr;
    logic [puf_pkg::NODE_W-1:0]       hist_rd_addr;
    logic                             flag;
    logic                             status;
    logic [puf_pkg::SIZE_W-1:0]       size;

    puf_node_mem u_node_mem (
        .i_clk     (i_clk),
        .i_wr      (node_wr),
        .i_rd_addr (node_rd_addr),
        .o_rd_data (node_q)
    );

    puf_hist_mem u_hist_mem (
        .i_clk     (i_clk),
        .i_wr      (hist_wr),
        .i_rd_addr (hist_rd_addr),
        .o_rd_data (hist_q)
    );

    puf_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .o_in_ready     (o_s_axis_tready),
        .i_opcode       (i_s_axis_tuser),
        .i_node_a       (i_s_axis_tdata[9:0]),
        .i_node_b       (i_s_axis_tdata[19:10]),
        .i_time         (i_s_axis_tdata[79:20]),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_flag         (flag),
        .o_size         (size),
        .o_status       (status),
        .o_node_wr      (node_wr),
        .o_node_rd_addr (node_rd_addr),
        .i_node_q       (node_q),
        .o_hist_wr      (hist_wr),
        .o_hist_rd_addr (hist_rd_addr),
        .i_hist_q       (hist_q)
    );

    assign o_m_axis_tdata = {3'b000, status, size, flag};

endmodule
